FILE: hw/rtl/ple_pkg.sv
package ple_pkg;

    // Default sizes
    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 30;
    localparam int TAYLOR_TERMS = 8;

    // Angle path, Q28 radians
    localparam int ANGLE_BITS = 31;
    localparam int ARG_BITS   = 30;
    localparam int DEG_BITS   = 9;
    localparam int ANG_FRAC   = 28;

    localparam logic [DEG_BITS:0]     ANGLE_OFFSET = 10'd270;
    localparam logic [DEG_BITS:0]     FULL_TURN    = 10'd360;
    localparam logic [DEG_BITS:0]     TWO_TURNS    = 10'd720;
    localparam logic [ANGLE_BITS-1:0] DEG_TO_RAD_Q = 31'd4685083;
    localparam logic [ANGLE_BITS-1:0] PI_Q         = 31'd843314857;
    localparam logic [ANGLE_BITS-1:0] HALF_PI_Q    = 31'd421657428;
    localparam logic [ANGLE_BITS-1:0] TWO_PI_Q     = 31'd1686629713;

endpackage

FILE: hw/rtl/polar_line_endpoint.sv
// Clock-hand line endpoint.
// Request channel: drive angle_deg, origin_x, origin_y and hand_length and
// raise start; the request is taken at the rising edge where start is high
// and busy is low. busy is always low, so a request can be taken every cycle.
// Result channel: start_x/start_y (dial center) and end_x/end_y (hand tip)
// are shown for exactly one cycle with done high. The receiver cannot stall,
// so nothing here waits on it.
// The result is taken at the rising edge that ends its done cycle.
// Throughput is one request per cycle. The pipeline holds angle reduction,
// squaring, the Horner chain with one register stage per series term, and
// the final scale and clamp stages. Horner stages hold a Horner multiplier
// and a reciprocal multiplier per lane, but the first has no Horner
// multiplier and the last no reciprocal one. Cosine and sine run as two
// parallel lanes.
// Reset clears the valid bits only; requests in flight are dropped and done
// stays low until a new request has passed the full pipeline.
module polar_line_endpoint #(
    parameter int COORD_BITS   = ple_pkg::COORD_BITS,
    parameter int FRAC_BITS    = ple_pkg::FRAC_BITS,
    parameter int TAYLOR_TERMS = ple_pkg::TAYLOR_TERMS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ple_pkg::DEG_BITS-1:0]  angle_deg,
    input  logic [COORD_BITS-1:0]         origin_x,
    input  logic [COORD_BITS-1:0]         origin_y,
    input  logic [COORD_BITS-1:0]         hand_length,
    output logic                          done,
    output logic [COORD_BITS:0]           start_x,
    output logic [COORD_BITS:0]           start_y,
    output logic [COORD_BITS+1:0]         end_x,
    output logic [COORD_BITS+1:0]         end_y
);

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int K   = TAYLOR_TERMS;
    localparam int AW  = ple_pkg::ANGLE_BITS;
    localparam int RW  = ple_pkg::ARG_BITS;
    localparam int N   = F + 4;                  // x^2 and quotient width
    localparam int HW  = F + 5;                  // signed Horner accumulator
    localparam int TW  = C + F + 7;              // end sum width
    localparam int SQ_SHIFT = 2 * ple_pkg::ANG_FRAC - F;
    localparam int LAT = K + 7;
    localparam logic [HW-1:0]  ONE_H = HW'(1) << F;
    localparam logic [C+1:0]   MAXV  = '1;

    typedef struct packed {
        logic [C-1:0] len;
        logic [C:0]   sx;
        logic [C:0]   sy;
    } side_t;

    // Valid bits travel with the data; one bit per stage.
    logic [LAT-1:0] valid_reg, valid_next;

    assign busy       = 1'b0;
    assign valid_next = {valid_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: offset and reduce the angle, form the dial center.
    logic [ple_pkg::DEG_BITS:0]   deg_sum;
    logic [ple_pkg::DEG_BITS-1:0] n_next, n_reg;
    side_t                        side1_next, side1_reg;

    always_comb
    begin
        deg_sum = {1'b0, angle_deg} + ple_pkg::ANGLE_OFFSET;
        if (deg_sum >= ple_pkg::TWO_TURNS)
        begin
            n_next = ple_pkg::DEG_BITS'(deg_sum - ple_pkg::TWO_TURNS);
        end
        else if (deg_sum >= ple_pkg::FULL_TURN)
        begin
            n_next = ple_pkg::DEG_BITS'(deg_sum - ple_pkg::FULL_TURN);
        end
        else
        begin
            n_next = ple_pkg::DEG_BITS'(deg_sum);
        end
        side1_next.len = hand_length;
        side1_next.sx  = {1'b0, origin_x} + {1'b0, hand_length};
        side1_next.sy  = {1'b0, origin_y} + {1'b0, hand_length};
    end

    // Stage 2: degrees to Q28 radians.
    logic [AW-1:0] theta_next, theta_reg;
    side_t         side2_reg;

    assign theta_next = AW'(n_reg) * ple_pkg::DEG_TO_RAD_Q;

    // Stage 3: the sine lane takes |theta - pi/2| as its cosine argument.
    logic [AW-1:0] arg_next [2];
    logic [AW-1:0] arg_reg  [2];
    side_t         side3_reg;

    always_comb
    begin
        arg_next[0] = theta_reg;
        if (theta_reg >= ple_pkg::HALF_PI_Q)
        begin
            arg_next[1] = theta_reg - ple_pkg::HALF_PI_Q;
        end
        else
        begin
            arg_next[1] = ple_pkg::HALF_PI_Q - theta_reg;
        end
    end

    // Stage 4: fold below 2*pi, then below pi with a sign flag.
    logic [RW-1:0] a_next [2];
    logic [RW-1:0] a_reg  [2];
    logic          neg_next [2];
    logic          neg4_reg [2];
    side_t         side4_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [AW-1:0] w;
            w = arg_reg[l];
            if (w >= ple_pkg::TWO_PI_Q)
            begin
                w = w - ple_pkg::TWO_PI_Q;
            end
            neg_next[l] = (w >= ple_pkg::PI_Q);
            if (neg_next[l])
            begin
                w = w - ple_pkg::PI_Q;
            end
            a_next[l] = w[RW-1:0];
        end
    end

    // Stage 5: square, cut to FRAC_BITS fraction bits.
    logic [2*RW-1:0] sq [2];
    logic [N-1:0]    x2_next [2];
    logic [N-1:0]    x2_reg  [2];
    logic            neg5_reg [2];
    side_t           side5_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sq[l]      = (2*RW)'(a_reg[l]) * (2*RW)'(a_reg[l]);
            x2_next[l] = N'(sq[l] >> SQ_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        side1_reg <= side1_next;
        theta_reg <= theta_next;
        side2_reg <= side1_reg;
        arg_reg   <= arg_next;
        side3_reg <= side2_reg;
        a_reg     <= a_next;
        neg4_reg  <= neg_next;
        side4_reg <= side3_reg;
        x2_reg    <= x2_next;
        neg5_reg  <= neg4_reg;
        side5_reg <= side4_reg;
    end

    // Horner stages. Stage j applies term K-j with the quotient made in the
    // stage before, and all but the last make the quotient for the next term
    // by a reciprocal multiply; stage 0 has no Horner multiply and starts at one.
    logic [N-1:0]         hx2_reg  [K-2][2];
    logic [N-1:0]         hq_reg   [K-1][2];
    logic signed [HW-1:0] hh_reg   [K][2];
    logic                 hneg_reg [K][2];
    side_t                hside_reg [K];

    for (genvar j = 0; j < K; j++)
    begin : g_horner
        if (j == 0)
        begin : g_side_first
            always_ff @(posedge clk)
            begin
                hside_reg[j] <= side5_reg;
            end
        end
        else
        begin : g_side_next
            always_ff @(posedge clk)
            begin
                hside_reg[j] <= hside_reg[j-1];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [N-1:0]         x2_in;
            logic                 neg_in;
            logic signed [HW-1:0] h_next;

            if (j == 0)
            begin : g_first
                assign x2_in  = x2_reg[l];
                assign neg_in = neg5_reg[l];
                assign h_next = signed'(ONE_H);
            end
            else
            begin : g_step
                logic [HW-1:0]   mag;
                logic [N+HW-1:0] prod;
                logic [HW-1:0]   p;
                logic            hs;
                assign hs     = hh_reg[j-1][l][HW-1];
                assign mag    = hs ? HW'(-hh_reg[j-1][l]) : HW'(hh_reg[j-1][l]);
                assign prod   = (N+HW)'(hq_reg[j-1][l]) * (N+HW)'(mag);
                assign p      = prod[F +: HW];
                // h = 1 - q*h, product magnitude truncated toward zero
                assign h_next = signed'(hs ? ONE_H + p : ONE_H - p);
                assign neg_in = hneg_reg[j-1][l];
                if (j < K-1)
                begin : g_x2
                    assign x2_in = hx2_reg[j-1][l];
                end
                else
                begin : g_x2_none
                    assign x2_in = '0;
                end
            end

            if (j < K-1)
            begin : g_div
                localparam longint unsigned TK = longint'(K - 1 - j);
                localparam longint unsigned D  = (2 * TK - 1) * (2 * TK);
                // Strip the power of two from the divisor by a shift, then
                // divide by the odd part with a reciprocal multiply.
                localparam int DS = (TK % 8 == 0) ? 4 : (TK % 4 == 0) ? 3 :
                                    (TK % 2 == 0) ? 2 : 1;
                localparam longint unsigned DO = D >> DS;
                localparam int XW  = N - DS;
                localparam int RSO = XW + $clog2(DO);
                localparam int MWO = RSO + 1;
                localparam longint unsigned M = ((64'd1 << RSO) + DO - 1) / DO;
                logic [XW-1:0]     xs;
                logic [XW+MWO-1:0] qp;
                logic [N-1:0]      q_next;
                assign xs     = XW'(x2_in >> DS);
                assign qp     = (XW+MWO)'(xs) * (XW+MWO)'(M);
                assign q_next = N'(qp[RSO +: XW]);
                always_ff @(posedge clk)
                begin
                    hq_reg[j][l] <= q_next;
                end
                if (j < K-2)
                begin : g_x2_keep
                    always_ff @(posedge clk)
                    begin
                        hx2_reg[j][l] <= x2_in;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                hh_reg[j][l]   <= h_next;
                hneg_reg[j][l] <= neg_in;
            end
        end
    end

    // Scale by the length and add the center.
    logic signed [HW-1:0] cval [2];
    logic signed [TW-1:0] tot_next [2];
    logic signed [TW-1:0] tot_reg  [2];
    logic [C:0]           sx_m_reg, sy_m_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [C:0] centre;
            centre  = (l == 0) ? hside_reg[K-1].sx : hside_reg[K-1].sy;
            cval[l] = hneg_reg[K-1][l] ? -hh_reg[K-1][l] : hh_reg[K-1][l];
            tot_next[l] = $signed({{(TW-C-1-F){1'b0}}, centre, {F{1'b0}}})
                        + $signed({{(TW-C){1'b0}}, hside_reg[K-1].len}) * TW'(cval[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        tot_reg  <= tot_next;
        sx_m_reg <= hside_reg[K-1].sx;
        sy_m_reg <= hside_reg[K-1].sy;
    end

    // Output stage: clamp negative sums to zero, saturate large ones.
    logic [C+1:0] end_next [2];
    logic [C+1:0] end_reg  [2];
    logic [C:0]   start_x_reg, start_y_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [TW-F-1:0] v;
            v = tot_reg[l][TW-1:F];
            if (tot_reg[l][TW-1])
            begin
                end_next[l] = '0;
            end
            else if (v > (TW-F)'(MAXV))
            begin
                end_next[l] = MAXV;
            end
            else
            begin
                end_next[l] = v[C+1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg     <= end_next;
        start_x_reg <= sx_m_reg;
        start_y_reg <= sy_m_reg;
    end

    assign done    = valid_reg[LAT-1];
    assign start_x = start_x_reg;
    assign start_y = start_y_reg;
    assign end_x   = end_reg[0];
    assign end_y   = end_reg[1];

    // Every accepted request comes out with done high at the end of the pipe.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request did not produce a result on time");

    // Center travels with its request.
    a_center: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT
            (start_x == $past({1'b0, origin_x} + {1'b0, hand_length}, LAT)))
        else $error("start_x does not match its request");

    // Twelve o'clock: the hand tip sits above the center.
    a_noon: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && angle_deg == '0) |-> ##LAT
            ({1'b0, end_y} == {1'b0, start_y} - {2'b0, $past(hand_length, LAT)}))
        else $error("twelve o'clock hand tip is off");

    // No request pending in the whole pipe means no result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |=> !done)
        else $error("result strobe without a request");

endmodule
